FILE: rtl/epsr_pkg.sv
// Package: types, constants and pair tables for the pair substitution rate block.
package epsr_pkg;
  localparam int NUM_STATES  = 4;
  localparam int COUNT_WIDTH = 16;
  localparam int NUM_PAIRS   = NUM_STATES * (NUM_STATES - 1) / 2;
  localparam int PAIR_W      = (NUM_PAIRS > 1) ? $clog2(NUM_PAIRS) : 1;
  localparam int STATE_W     = 2;
  localparam int SUM_W       = 32;
  localparam int RATE_W      = 22;
  localparam int QUO_W       = 49;
  localparam logic [RATE_W-1:0] RATE_MIN = 22'd655;
  localparam logic [RATE_W-1:0] RATE_MAX = 22'd3276800;
  localparam logic [RATE_W-1:0] RATE_ONE = 22'd65536;
  localparam int QDEPTH = 2;

  typedef struct packed {
    logic        mode;
    logic [3:0]  tip_states;
    logic [15:0] site_weight;
    logic        last_of_site;
  } in_word_t;

  typedef struct packed {
    logic [RATE_W-1:0]  rate;
    logic [STATE_W-1:0] state_first;
    logic [STATE_W-1:0] state_second;
    logic               last;
  } out_word_t;

  typedef enum logic [1:0] {
    OP_COUNT  = 2'd0,
    OP_CLOSE  = 2'd1,
    OP_FINISH = 2'd2
  } op_t;

  typedef struct packed {
    op_t                    op;
    logic [NUM_STATES-1:0]  inc;
    logic [15:0]            weight;
  } cmd_t;

  function automatic logic [STATE_W-1:0] pair_a(input logic [PAIR_W-1:0] p);
    int k;
    logic [STATE_W-1:0] r;
    k = 0;
    r = '0;
    for (int a = 0; a < NUM_STATES; a++)
      for (int b = a + 1; b < NUM_STATES; b++) begin
        if (k == int'(p)) r = STATE_W'(a);
        k++;
      end
    return r;
  endfunction

  function automatic logic [STATE_W-1:0] pair_b(input logic [PAIR_W-1:0] p);
    int k;
    logic [STATE_W-1:0] r;
    k = 0;
    r = '0;
    for (int a = 0; a < NUM_STATES; a++)
      for (int b = a + 1; b < NUM_STATES; b++) begin
        if (k == int'(p)) r = STATE_W'(b);
        k++;
      end
    return r;
  endfunction
endpackage

FILE: rtl/epsr_front.sv
// Front end: classifies words into commands and queues them.
module epsr_front import epsr_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  in_word_t in_data,
  output logic     cmd_valid,
  input  logic     cmd_ready,
  output cmd_t     cmd_data
);
  cmd_t q_r [QDEPTH];
  logic [1:0] cnt_r, cnt_nxt;
  logic       rd_r, rd_nxt, wr_r, wr_nxt;
  cmd_t       c;
  logic       push, pop;
  localparam logic [NUM_STATES-1:0] UNDEF = '1;

  always_comb begin
    c.weight = in_data.site_weight;
    if (in_data.mode) begin
      c.op  = OP_FINISH;
      c.inc = '0;
    end else begin
      c.op  = in_data.last_of_site ? OP_CLOSE : OP_COUNT;
      c.inc = (in_data.tip_states[NUM_STATES-1:0] == UNDEF) ? '0
            : in_data.tip_states[NUM_STATES-1:0];
    end
  end

  assign in_ready  = (cnt_r != 2'(QDEPTH));
  assign push      = in_valid && in_ready;
  assign cmd_valid = (cnt_r != 2'd0);
  assign pop       = cmd_valid && cmd_ready;
  assign cmd_data  = q_r[rd_r];

  always_comb begin
    cnt_nxt = cnt_r + 2'(push) - 2'(pop);
    rd_nxt  = pop ? ~rd_r : rd_r;
    wr_nxt  = push ? ~wr_r : wr_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      rd_r  <= 1'b0;
      wr_r  <= 1'b0;
    end else begin
      cnt_r <= cnt_nxt;
      rd_r  <= rd_nxt;
      wr_r  <= wr_nxt;
    end
    if (push) q_r[wr_r] <= c;
  end

  a_cnt: assert property (@(posedge clk) disable iff (!rst_n) cnt_r <= 2'(QDEPTH))
    else $error("queue overfill");
  a_full: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == 2'(QDEPTH)) |-> !in_ready) else $error("ready when full");
  a_pop: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == 2'd0) |-> !cmd_valid) else $error("valid when empty");
endmodule

FILE: rtl/epsr_back.sv
// Back end: state counts, pair accumulation, divider and result stage.
module epsr_back import epsr_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      cmd_valid,
  output logic      cmd_ready,
  input  cmd_t      cmd_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_word_t out_data
);
  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_MAC  = 4'b0010,
    S_DIV  = 4'b0100,
    S_OUT  = 4'b1000
  } st_t;

  st_t st_r, st_nxt;
  logic [COUNT_WIDTH-1:0] cnt_r [NUM_STATES];
  logic [SUM_W-1:0]       sum_r [NUM_PAIRS];
  logic [PAIR_W-1:0]      p_r;
  logic [15:0]            w_r;
  logic [SUM_W-1:0]       prod_r;
  logic                   ph_r;
  logic [SUM_W-1:0]       div_r;
  logic [QUO_W-1:0]       num_r, quo_r;
  logic [SUM_W:0]         rem_r;
  logic [5:0]             bit_r;
  logic                   ov_r;
  out_word_t              o_r;
  logic                   ov_nxt;

  localparam logic [PAIR_W-1:0] PLAST = PAIR_W'(NUM_PAIRS - 1);
  logic [SUM_W:0] rsh;
  logic [SUM_W:0] rdiff;

  assign cmd_ready = (st_r == S_IDLE);
  assign out_valid = ov_r;
  assign out_data  = o_r;
  assign rsh   = {rem_r[SUM_W-1:0], num_r[QUO_W-1]};
  assign rdiff = rsh - {1'b0, div_r};

  always_comb begin
    st_nxt = st_r;
    ov_nxt = ov_r;
    if (ov_r && out_ready) ov_nxt = 1'b0;
    unique case (st_r)
      S_IDLE: if (cmd_valid) begin
        if (cmd_data.op == OP_CLOSE) st_nxt = S_MAC;
        else if (cmd_data.op == OP_FINISH) st_nxt = S_DIV;
      end
      S_MAC: if (ph_r && p_r == PLAST) st_nxt = S_IDLE;
      S_DIV: if (bit_r == 6'(QUO_W)) st_nxt = S_OUT;
      S_OUT: if (!ov_r || out_ready) begin
        ov_nxt = 1'b1;
        st_nxt = (p_r == PLAST) ? S_IDLE : S_DIV;
      end
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE;
      ov_r <= 1'b0;
      for (int i = 0; i < NUM_STATES; i++) cnt_r[i] <= '0;
      for (int i = 0; i < NUM_PAIRS; i++) sum_r[i] <= '0;
      p_r <= '0; ph_r <= 1'b0; bit_r <= '0;
    end else begin
      st_r <= st_nxt;
      ov_r <= ov_nxt;
      unique case (st_r)
        S_IDLE: if (cmd_valid) begin
          for (int i = 0; i < NUM_STATES; i++)
            if (cmd_data.inc[i]) cnt_r[i] <= cnt_r[i] + 1'b1;
          w_r  <= cmd_data.weight;
          p_r  <= '0;
          ph_r <= 1'b0;
          bit_r <= '0;
          div_r <= (sum_r[PLAST] == '0) ? SUM_W'(1) : sum_r[PLAST];
          num_r <= {1'b0, sum_r[0], 16'd0};
          rem_r <= '0;
        end
        S_MAC: begin
          if (!ph_r) begin
            prod_r <= SUM_W'(cnt_r[pair_a(p_r)]) * SUM_W'(cnt_r[pair_b(p_r)]);
          end else begin
            sum_r[p_r] <= sum_r[p_r] + prod_r * SUM_W'(w_r);
            p_r <= p_r + 1'b1;
            if (p_r == PLAST)
              for (int i = 0; i < NUM_STATES; i++) cnt_r[i] <= '0;
          end
          ph_r <= ~ph_r;
        end
        S_DIV: if (bit_r != 6'(QUO_W)) begin
          if (!rdiff[SUM_W]) begin
            rem_r <= rdiff;
            quo_r <= {quo_r[QUO_W-2:0], 1'b1};
          end else begin
            rem_r <= rsh;
            quo_r <= {quo_r[QUO_W-2:0], 1'b0};
          end
          num_r <= {num_r[QUO_W-2:0], 1'b0};
          bit_r <= bit_r + 1'b1;
        end
        S_OUT: if (!ov_r || out_ready) begin
          o_r.state_first  <= pair_a(p_r);
          o_r.state_second <= pair_b(p_r);
          o_r.last         <= (p_r == PLAST);
          if (p_r == PLAST) o_r.rate <= RATE_ONE;
          else if ({rem_r, 1'b0} >= {2'b0, div_r}) begin
            if (quo_r + 1'b1 > QUO_W'(RATE_MAX)) o_r.rate <= RATE_MAX;
            else if (quo_r + 1'b1 < QUO_W'(RATE_MIN)) o_r.rate <= RATE_MIN;
            else o_r.rate <= RATE_W'(quo_r + 1'b1);
          end else begin
            if (quo_r > QUO_W'(RATE_MAX)) o_r.rate <= RATE_MAX;
            else if (quo_r < QUO_W'(RATE_MIN)) o_r.rate <= RATE_MIN;
            else o_r.rate <= RATE_W'(quo_r);
          end
          if (p_r == PLAST) begin
            for (int i = 0; i < NUM_PAIRS; i++) sum_r[i] <= '0;
          end else begin
            p_r   <= p_r + 1'b1;
            bit_r <= '0;
            rem_r <= '0;
            num_r <= {1'b0, sum_r[p_r + 1'b1], 16'd0};
          end
        end
        default: ;
      endcase
    end
  end

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> out_valid) else $error("result dropped");
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r != S_IDLE) |-> !cmd_ready) else $error("accept while busy");
  a_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.last) |-> out_data.rate == RATE_ONE) else $error("last rate");
endmodule

FILE: rtl/empirical_pair_substitution_rates_top.sv
// Top level: pair substitution rate estimator.
//   channel | dir | handshake             | payload
//   in      | in  | in_valid / in_ready   | in_data  (in_word_t)
//   out     | out | out_valid / out_ready | out_data (out_word_t)
// Count words are taken in IDLE; a site-closing word then multiplies and
// accumulates each pair. Finish: a bit-serial division per pair, then output.
// A two-entry command queue decouples input from the back end.
// Synchronous active-low reset clears counts, sums, queue and result stage.
// A stalled result holds the back end; input keeps filling the queue.
module empirical_pair_substitution_rates_top import epsr_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_word_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_word_t out_data
);
  logic cmd_valid, cmd_ready;
  cmd_t cmd_data;

  epsr_front u_front (.clk, .rst_n, .in_valid, .in_ready, .in_data,
    .cmd_valid, .cmd_ready, .cmd_data);
  epsr_back u_back (.clk, .rst_n, .cmd_valid, .cmd_ready, .cmd_data,
    .out_valid, .out_ready, .out_data);
endmodule

FILE: sim/epsr_checker.sv
// Checker: predicts pair substitution rates from accepted input words and compares outputs.
module epsr_checker import epsr_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  input  logic      in_ready,
  input  in_word_t  in_data,
  input  logic      out_valid,
  input  logic      out_ready,
  input  out_word_t out_data,
  output int        errors,
  output int        pending,
  output int        rates_seen
);
  timeunit 1ns;
  timeprecision 1ps;

  logic [COUNT_WIDTH-1:0] counts [NUM_STATES];
  logic [SUM_W-1:0]       sums [NUM_PAIRS];
  out_word_t              rate_q [$];

  assign pending = rate_q.size();

  task automatic absorb_word(input in_word_t w);
    logic [63:0] divisor, q;
    int p;
    p = 0;
    if (w.mode == 1'b0) begin
      if (w.tip_states != {NUM_STATES{1'b1}})
        for (int s = 0; s < NUM_STATES; s++)
          if (w.tip_states[s]) counts[s] = counts[s] + 1'b1;
      if (w.last_of_site) begin
        for (int a = 0; a < NUM_STATES; a++)
          for (int b = a + 1; b < NUM_STATES; b++) begin
            sums[p] = sums[p] + SUM_W'(32'(counts[a]) * 32'(counts[b]) * 32'(w.site_weight));
            p++;
          end
        for (int s = 0; s < NUM_STATES; s++) counts[s] = '0;
      end
    end else begin
      divisor = (sums[NUM_PAIRS-1] == 0) ? 64'd1 : 64'(sums[NUM_PAIRS-1]);
      for (int a = 0; a < NUM_STATES; a++)
        for (int b = a + 1; b < NUM_STATES; b++) begin
          out_word_t e;
          q = ((64'(sums[p]) << 16) + (divisor >> 1)) / divisor;
          if (q < 64'(RATE_MIN)) q = 64'(RATE_MIN);
          if (q > 64'(RATE_MAX)) q = 64'(RATE_MAX);
          if (p == NUM_PAIRS - 1) q = 64'(RATE_ONE);
          e.rate = q[RATE_W-1:0];
          e.state_first = STATE_W'(a);
          e.state_second = STATE_W'(b);
          e.last = (p == NUM_PAIRS - 1);
          rate_q.push_back(e);
          p++;
        end
      for (int k = 0; k < NUM_PAIRS; k++) sums[k] = '0;
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      for (int s = 0; s < NUM_STATES; s++) counts[s] = '0;
      for (int k = 0; k < NUM_PAIRS; k++) sums[k] = '0;
      rate_q.delete();
      errors <= 0;
      rates_seen <= 0;
    end else begin
      if (out_valid && out_ready) begin
        rates_seen <= rates_seen + 1;
        if (rate_q.size() == 0) begin
          $display("%0t: unexpected word %p", $time, out_data);
          errors <= errors + 1;
        end else begin
          out_word_t e;
          e = rate_q.pop_front();
          if (e !== out_data) begin
            $display("%0t: expected %p actual %p", $time, e, out_data);
            errors <= errors + 1;
          end
        end
      end
      if (in_valid && in_ready) absorb_word(in_data);
    end
  end
endmodule

FILE: sim/tb_empirical_pair_substitution_rates_top.sv
// Testbench top: stimulus, stall phases and verdict for the pair substitution rate block.
module tb_empirical_pair_substitution_rates_top;
  import epsr_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_ready;
  in_word_t  in_data = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_word_t out_data;
  int        errors, pending, rates_seen;
  int        in_idle_pct = 0, out_stall_pct = 0;
  int        idle_cycles = 0;
  int        words_sent = 0;

  always #1 clk = ~clk;

  empirical_pair_substitution_rates_top u_top (.*);

  epsr_checker u_chk (.clk, .rst_n, .in_valid, .in_ready, .in_data, .out_valid,
    .out_ready, .out_data, .errors, .pending, .rates_seen);

  always @(posedge clk)
    out_ready <= ($urandom_range(99) >= out_stall_pct);

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 20000) begin
      $display("empirical_pair_substitution_rates_top: mismatch");
      $finish;
    end
  end

  task automatic send_word(input logic m, input logic [3:0] t, input logic [15:0] w,
                           input logic l);
    in_word_t x;
    x.mode = m;
    x.tip_states = t;
    x.site_weight = w;
    x.last_of_site = l;
    while ($urandom_range(99) < in_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= x;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    words_sent++;
  endtask

  task automatic random_site();
    int n;
    n = $urandom_range(1, 6);
    for (int k = 0; k < n; k++)
      send_word(1'b0, 4'($urandom), 16'($urandom), k == n - 1);
  endtask

  initial begin
    int phase;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    send_word(1'b1, 4'hF, 16'hFFFF, 1'b1);
    send_word(1'b0, 4'h0, 16'h0, 1'b0);
    send_word(1'b0, 4'hF, 16'h0, 1'b0);
    send_word(1'b0, 4'h3, 16'h0, 1'b0);
    send_word(1'b0, 4'hC, 16'h0, 1'b0);
    send_word(1'b0, 4'h1, 16'h2, 1'b1);
    send_word(1'b1, 4'h0, 16'h0, 1'b0);
    send_word(1'b0, 4'h7, 16'h0, 1'b0);
    send_word(1'b0, 4'hE, 16'hFFFF, 1'b1);
    send_word(1'b0, 4'h9, 16'h0, 1'b0);
    send_word(1'b0, 4'h6, 16'h1, 1'b1);
    send_word(1'b1, 4'hA, 16'h5, 1'b1);
    send_word(1'b0, 4'h5, 16'h0, 1'b0);
    send_word(1'b0, 4'hB, 16'h0, 1'b0);
    send_word(1'b0, 4'hD, 16'h8000, 1'b1);
    send_word(1'b1, 4'h0, 16'h0, 1'b0);
    // long site to push counts and sums toward wrap
    for (int k = 0; k < 80; k++) send_word(1'b0, 4'h7, 16'hFFFF, 1'b0);
    send_word(1'b0, 4'h8, 16'hFFFF, 1'b1);
    send_word(1'b1, 4'h0, 16'h0, 1'b0);
    phase = 0;
    while (phase < 4) begin
      case (phase % 4)
        0: begin in_idle_pct = 0;  out_stall_pct = 0;  end
        1: begin in_idle_pct = 67; out_stall_pct = 0;  end
        2: begin in_idle_pct = 0;  out_stall_pct = 67; end
        default: begin in_idle_pct = 10; out_stall_pct = 10; end
      endcase
      for (int s = 0; s < 12; s++) begin
        if ($urandom_range(9) == 0) send_word(1'b0, 4'($urandom), 16'($urandom), 1'b0);
        else random_site();
      end
      send_word(1'b1, 4'($urandom), 16'($urandom), 1'($urandom));
      phase++;
    end
    in_valid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (400) @(posedge clk);
    $display("Sent %0d input words over %0d stall phases; checked %0d rate words.",
             words_sent, phase, rates_seen);
    if (errors == 0 && pending == 0)
      $display("empirical_pair_substitution_rates_top: match");
    else
      $display("empirical_pair_substitution_rates_top: mismatch");
    $finish;
  end
endmodule
